@@ src/scalar_kalman_smoother_core_macros.svh @@
// Assertion macros shared by the verification side of the scalar Kalman smoother.
// Needs nothing else; take it in by `include.
`ifndef SCALAR_KALMAN_SMOOTHER_CORE_MACROS_SVH
`define SCALAR_KALMAN_SMOOTHER_CORE_MACROS_SVH

// Same-cycle implication, checked while the given reset is low.
`define SKS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked while the given reset is low.
`define SKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/sks_pkg.sv @@
// Shared types and constants of the scalar Kalman smoother.
// No dependencies; used by the core and its checker.
package sks_pkg;

   localparam int DATA_W     = 32;
   localparam int GAIN_W     = 17;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int DIV_STEPS  = GAIN_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);
   localparam int MUL_A_W    = DATA_W + 2;
   localparam int MUL_B_W    = GAIN_W + 1;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;

   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_W);

   localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET = 32'd655;
   localparam logic [DATA_W-1:0] MEASURE_NOISE_RESET = 32'd16384;
   localparam logic [DATA_W-1:0] COV_RESET           = 32'd1311;
   localparam logic [DATA_W-1:0] EST_RESET           = 32'd65536;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_NOISE = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREDICT,
      ST_DIVIDE,
      ST_MUL_EST,
      ST_MUL_COV,
      ST_FINISH
   } state_type;

endpackage

@@ src/scalar_kalman_smoother_core.sv @@
// Scalar Kalman smoother: one measurement in, one estimate and gain out per beat.
// Depends on sks_pkg.
//
// Each accepted measurement runs through the sequencer from the req beat to rsp_valid:
// the predict state predicts the covariance, the restoring divider forms the Q1.16
// gain one quotient bit per cycle, the estimate update and the covariance shrink
// share one signed 34x18 multiplier, and the finish state loads the result register.
// req_ready is high only while the sequencer is idle; a previous result still
// waiting on rsp_ready holds the sequencer in the finish state before it goes idle.
// The csr port is always ready; write it only while the block is idle.
module scalar_kalman_smoother_core
   import sks_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [31:0]    req_measurement,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_estimate,
   output logic [16:0]           rsp_gain,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_wdata
);

   state_type state_ff, state_in;

   logic [DATA_W-1:0]        q_ff, r_ff;
   logic [DATA_W-1:0]        cov_ff;
   logic signed [DATA_W-1:0] est_ff;
   logic signed [DATA_W-1:0] meas_ff;
   logic [DATA_W-1:0]        p_ff;
   logic [DATA_W:0]          den_ff;
   logic [DATA_W:0]          rem_ff;
   logic [GAIN_W-1:0]        bits_ff;
   logic [GAIN_W-1:0]        quot_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_est_ff;
   logic [GAIN_W-1:0]        rsp_gain_ff;

   // control decoded from the state
   logic take_req, do_predict, do_divide, do_mul, do_est, emit;

   // datapath
   logic [DATA_W:0]          p_sum;
   logic [DATA_W-1:0]        p_sat;
   logic [DATA_W+1:0]        rem_shift;
   logic                     rem_ge;
   logic [GAIN_W-1:0]        k_w;
   logic signed [DATA_W:0]   diff_w;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [PROD_W-FRAC_W-1:0] delta_w;
   logic signed [PROD_W-FRAC_W:0]   est_sum;
   logic signed [DATA_W-1:0] est_sat;

   assign csr_ready    = 1'b1;
   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = rsp_est_ff;
   assign rsp_gain     = rsp_gain_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_PREDICT;
         ST_PREDICT: state_in = ST_DIVIDE;
         ST_DIVIDE:  if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = ST_MUL_EST;
         ST_MUL_EST: state_in = ST_MUL_COV;
         ST_MUL_COV: state_in = ST_FINISH;
         ST_FINISH:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // state decode
   always_comb begin
      take_req   = 1'b0;
      do_predict = 1'b0;
      do_divide  = 1'b0;
      do_mul     = 1'b0;
      do_est     = 1'b0;
      emit       = 1'b0;
      case (state_ff)
         ST_IDLE:    take_req = req_valid;
         ST_PREDICT: do_predict = 1'b1;
         ST_DIVIDE:  do_divide = 1'b1;
         ST_MUL_EST: do_mul = 1'b1;
         ST_MUL_COV: begin
            do_mul = 1'b1;
            do_est = 1'b1;
         end
         ST_FINISH:  emit = !rsp_valid_ff || rsp_ready;
         default:    ;
      endcase
   end

   // predicted covariance, saturated
   assign p_sum = {1'b0, cov_ff} + {1'b0, q_ff};
   assign p_sat = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];

   // one restoring divider step
   assign rem_shift = {rem_ff, bits_ff[GAIN_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};

   // a zero denominator forces a zero gain
   assign k_w    = (den_ff == '0) ? '0 : quot_ff;
   assign diff_w = {meas_ff[DATA_W-1], meas_ff} - {est_ff[DATA_W-1], est_ff};

   // shared multiplier: innovation * k, then (1 - k) * p
   always_comb begin
      if (state_ff == ST_MUL_EST) begin
         mul_a = {diff_w[DATA_W], diff_w};
         mul_b = {1'b0, k_w};
      end else begin
         mul_a = {2'b00, p_ff};
         mul_b = {1'b0, GAIN_ONE - k_w};
      end
   end
   assign mul_p = mul_a * mul_b;

   // dropping the low bits of a signed product gives the floor of the scaled delta
   assign delta_w = $signed(prod_ff[PROD_W-1:FRAC_W]);
   assign est_sum = {{(PROD_W-FRAC_W-DATA_W+1){est_ff[DATA_W-1]}}, est_ff}
                    + {delta_w[PROD_W-FRAC_W-1], delta_w};
   always_comb begin
      if (est_sum > $signed({{(PROD_W-FRAC_W-DATA_W+2){1'b0}}, {(DATA_W-1){1'b1}}}))
         est_sat = {1'b0, {(DATA_W-1){1'b1}}};
      else if (est_sum < $signed({{(PROD_W-FRAC_W-DATA_W+2){1'b1}}, {(DATA_W-1){1'b0}}}))
         est_sat = {1'b1, {(DATA_W-1){1'b0}}};
      else
         est_sat = est_sum[DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         q_ff         <= PROCESS_NOISE_RESET;
         r_ff         <= MEASURE_NOISE_RESET;
         cov_ff       <= COV_RESET;
         est_ff       <= EST_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PROCESS_NOISE) q_ff <= csr_wdata;
            if (csr_index == CSR_MEASURE_NOISE) r_ff <= csr_wdata;
         end
         if (do_est) est_ff <= est_sat;
         if (emit) begin
            cov_ff       <= prod_ff[DATA_W+FRAC_W-1:FRAC_W];
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_req) meas_ff <= req_measurement;
      if (do_predict) begin
         p_ff    <= p_sat;
         den_ff  <= {1'b0, p_sat} + {1'b0, r_ff};
         rem_ff  <= {2'b00, p_sat[DATA_W-1:1]};
         bits_ff <= {p_sat[0], {(GAIN_W-1){1'b0}}};
         quot_ff <= '0;
         cnt_ff  <= '0;
      end
      if (do_divide) begin
         rem_ff  <= rem_ge ? (DATA_W+1)'(rem_shift - {1'b0, den_ff})
                           : rem_shift[DATA_W:0];
         bits_ff <= {bits_ff[GAIN_W-2:0], 1'b0};
         quot_ff <= {quot_ff[GAIN_W-2:0], rem_ge};
         cnt_ff  <= cnt_ff + CNT_W'(1);
      end
      if (do_mul) prod_ff <= mul_p;
      // load the result only once the previous beat has left
      if (emit) begin
         rsp_gain_ff <= k_w;
         rsp_est_ff  <= est_ff;
      end
   end

endmodule

@@ src/sks_checker.sv @@
// Port-level checker for the scalar Kalman smoother, bound to the core module.
// Depends on sks_pkg and scalar_kalman_smoother_core_macros.svh.
`include "scalar_kalman_smoother_core_macros.svh"

module sks_checker
   import sks_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic signed [31:0]    rsp_estimate,
   input logic [16:0]           rsp_gain
);

   // a stalled result beat holds its payload
   `SKS_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_estimate) && $stable(rsp_gain))

   // the gain never exceeds one
   `SKS_ASSERT_NOW(gain_range_a, clock, reset, rsp_valid, rsp_gain <= GAIN_ONE)

   // an accepted measurement keeps the block busy
   `SKS_ASSERT_NEXT(busy_a, clock, reset, req_valid && req_ready, !req_ready)

   // reset leaves no result pending and the block ready
   `SKS_ASSERT_NEXT(reset_a, clock, 1'b0, reset, !rsp_valid && req_ready)

endmodule

bind scalar_kalman_smoother_core sks_checker u_sks_checker (.*);

@@ sim/tb_top.sv @@
// Self-checking bench for scalar_kalman_smoother_core: directed and random samples
// against an in-bench fixed-point filter. Depends on sks_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
   import sks_pkg::*;

   localparam int SETTLE_CYCLES = 30;
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 125;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic signed [31:0] estimate;
      logic [16:0]        gain;
   } filter_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [31:0]   req_measurement = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [31:0]   rsp_estimate;
   logic [16:0]          rsp_gain;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   logic [31:0]        sample_queue[$];
   filter_out_type     expected_out[$];
   int                 send_idle = 35;
   int                 recv_idle = 55;
   int                 error_count = 0;
   int                 stall_cycles = 0;

   // filter state and noise settings as the bench sees them
   logic [31:0]        model_cov;
   logic signed [31:0] model_est;
   logic [31:0]        model_q;
   logic [31:0]        model_r;

   scalar_kalman_smoother_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_estimate    (rsp_estimate),
      .rsp_gain        (rsp_gain),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // One filter step: predict covariance, form gain, pull estimate, shrink covariance.
   function automatic filter_out_type kalman_update(input logic signed [31:0] meas);
      logic [63:0]        p;
      logic [63:0]        den;
      logic [63:0]        k;
      logic signed [63:0] diff;
      logic signed [63:0] pull;
      logic signed [63:0] est_next;
      filter_out_type     res;
      p = {32'd0, model_cov} + {32'd0, model_q};
      if (p > 64'hFFFF_FFFF)
         p = 64'hFFFF_FFFF;
      den = p + {32'd0, model_r};
      k = (den != 64'd0) ? (p << 16) / den : 64'd0;
      if (k > 64'd65536)
         k = 64'd65536;
      diff = $signed({{32{meas[31]}}, meas}) - $signed({{32{model_est[31]}}, model_est});
      // arithmetic shift floors toward minus infinity
      pull = (diff * $signed(k)) >>> 16;
      est_next = $signed({{32{model_est[31]}}, model_est}) + pull;
      if (est_next > 64'sh0000_0000_7FFF_FFFF)
         est_next = 64'sh0000_0000_7FFF_FFFF;
      if (est_next < -64'sh0000_0000_8000_0000)
         est_next = -64'sh0000_0000_8000_0000;
      model_est = est_next[31:0];
      model_cov = 32'(((64'd65536 - k) * p) >> 16);
      res.estimate = model_est;
      res.gain = k[16:0];
      return res;
   endfunction

   function automatic logic [31:0] pick_measurement();
      case ($urandom_range(15))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3, 4, 5: return $urandom();
         default: return 32'($urandom_range(2097152)) - 32'd1048576;
      endcase
   endfunction

   // driver: advance to the next sample once the current beat is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_valid <= 1'b1;
            req_measurement <= sample_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // monitor: track config, predict on each sample beat, check each result beat
   always @(posedge clock) begin
      filter_out_type want;
      if (reset) begin
         model_cov = COV_RESET;
         model_est = EST_RESET;
         model_q = PROCESS_NOISE_RESET;
         model_r = MEASURE_NOISE_RESET;
         stall_cycles = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PROCESS_NOISE: model_q = csr_wdata;
               CSR_MEASURE_NOISE: model_r = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_out.push_back(kalman_update(req_measurement));
         if (rsp_valid && rsp_ready) begin
            if (expected_out.size() == 0) begin
               $error("result beat with no sample pending: estimate %0d gain %0d",
                      rsp_estimate, rsp_gain);
               error_count++;
            end else begin
               want = expected_out.pop_front();
               if (rsp_estimate !== want.estimate) begin
                  $error("estimate: expected %0d, got %0d", want.estimate, rsp_estimate);
                  error_count++;
               end
               if (rsp_gain !== want.gain) begin
                  $error("gain: expected %0d, got %0d", want.gain, rsp_gain);
                  error_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_noise(input logic [31:0] q, input logic [31:0] r);
      write_csr(CSR_PROCESS_NOISE, q);
      write_csr(CSR_MEASURE_NOISE, r);
   endtask

   // hold until every sample is answered, then let the sequencer settle
   task automatic wait_drained();
      while (sample_queue.size() != 0 || req_valid || expected_out.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset noise settings, sample extremes
      sample_queue.push_back(32'h0000_0000);
      sample_queue.push_back(32'h7FFF_FFFF);
      sample_queue.push_back(32'h8000_0000);
      sample_queue.push_back(32'h7FFF_FFFF);
      sample_queue.push_back(32'hFFFF_FFFF);
      sample_queue.push_back(32'h0000_0001);
      sample_queue.push_back(32'h0001_0000);
      wait_drained();

      // no noise at all: gain goes to one, then the denominator collapses to zero
      set_noise(32'h0, 32'h0);
      sample_queue.push_back(32'h8000_0000);
      sample_queue.push_back(32'h7FFF_FFFF);
      sample_queue.push_back(32'h0000_3039);
      wait_drained();

      // saturating covariance prediction
      set_noise(32'hFFFF_FFFF, 32'h0);
      sample_queue.push_back(32'h7FFF_FFFF);
      sample_queue.push_back(32'h8000_0000);
      wait_drained();
      set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      sample_queue.push_back(32'h8000_0000);
      sample_queue.push_back(32'h7FFF_FFFF);
      wait_drained();

      // writes to unused indexes must leave both noise settings alone
      write_csr(CSR_SPARE_LO, 32'h0000_0000);
      write_csr(CSR_SPARE_HI, 32'hFFFF_FFFF);
      sample_queue.push_back(32'hFFF0_0000);
      sample_queue.push_back(32'h0010_0000);
      wait_drained();

      // tiny gain
      set_noise(32'h1, 32'hFFFF_FFFF);
      sample_queue.push_back(32'h7FFF_FFFF);
      sample_queue.push_back(32'h8000_0000);
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph / 2)
            0: begin
               send_idle = 35;
               recv_idle = 55;
            end
            1: begin
               send_idle = 55;
               recv_idle = 35;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         case (ph)
            0: set_noise(PROCESS_NOISE_RESET, MEASURE_NOISE_RESET);
            1: set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            2: set_noise(32'h0, $urandom());
            3: set_noise($urandom_range(65536), 32'h0);
            4: begin
               set_noise($urandom(), $urandom());
               write_csr(CSR_SPARE_LO, $urandom());
               write_csr(CSR_SPARE_HI, $urandom());
            end
            default: set_noise($urandom_range(4096), $urandom_range(1048576));
         endcase
         repeat (PHASE_ITEMS) sample_queue.push_back(pick_measurement());
         wait_drained();
      end

      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ scalar_kalman_smoother_core.f @@
+incdir+src
src/sks_pkg.sv
src/scalar_kalman_smoother_core.sv
src/sks_checker.sv
sim/tb_top.sv
